// ----- hdl/sffs_pkg.sv -----
// ----------------------------------------------------------------------------
// sffs_pkg
// shared field widths, item kind codes, class codes and item structs
// ----------------------------------------------------------------------------
`default_nettype none

package sffs_pkg;

    localparam int KIND_W = 2;
    localparam int BIN_W  = 10;
    localparam int MAG_W  = 24;
    localparam int PH_W   = 16;
    localparam int DRAW_W = 16;
    localparam int CFG_W  = 7;

    // bins addressable through the bin field
    localparam int BIN_SPAN = 1 << BIN_W;

    localparam logic [KIND_W-1:0] KIND_BIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NYQ = 2'd2;

    // what the back end does with an item
    typedef enum logic [1:0] {
        CLS_BIN  = 2'd0,
        CLS_DC   = 2'd1,
        CLS_NYQ  = 2'd2,
        CLS_ECHO = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls                     cls;
        logic                     freeze;
        logic [KIND_W-1:0]        kind;
        logic [BIN_W-1:0]         bin_index;
        logic signed [MAG_W-1:0]  magnitude;
        logic [PH_W-1:0]          phase;
        logic                     frame_end;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]        kind_out;
        logic [BIN_W-1:0]         bin_out;
        logic signed [MAG_W-1:0]  magnitude_out;
        logic [PH_W-1:0]          phase_out;
        logic                     last;
    } t_res;

endpackage

`default_nettype wire

// ----- hdl/sffs_fifo.sv -----
// ----------------------------------------------------------------------------
// sffs_fifo
// small register queue with full and empty flags
// ----------------------------------------------------------------------------
`default_nettype none

module sffs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sffs_front.sv -----
// ----------------------------------------------------------------------------
// sffs_front
// frame count register, write slot, item classification and frame pick
// ----------------------------------------------------------------------------
`default_nettype none

module sffs_front #(
    parameter int MAX_FRAMES = 64,
    parameter int MAX_BINS   = 1024,
    parameter int FRAME_W    = 6,
    parameter int FCNT_W     = 7
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sffs_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_take,
    input  wire logic [sffs_pkg::KIND_W-1:0]        i_kind,
    input  wire logic                               i_freeze,
    input  wire logic [sffs_pkg::BIN_W-1:0]         i_bin_index,
    input  wire logic signed [sffs_pkg::MAG_W-1:0]  i_magnitude,
    input  wire logic [sffs_pkg::PH_W-1:0]          i_phase,
    input  wire logic [sffs_pkg::DRAW_W-1:0]        i_random_draw,
    input  wire logic                               i_frame_end,
    output sffs_pkg::t_cmd                          o_cmd,
    output logic [FRAME_W-1:0]                      o_pick,
    output logic [FRAME_W-1:0]                      o_slot
);

    localparam int PROD_W = sffs_pkg::DRAW_W + FCNT_W;

    logic [FCNT_W-1:0]  r_frames, n_frames;
    logic [FRAME_W-1:0] r_slot, n_slot;
    logic [PROD_W-1:0]  prod;
    sffs_pkg::t_cls     cls;

    // clamp to 1..MAX_FRAMES
    always_comb begin
        n_frames = r_frames;
        if (i_cfg_we) begin
            priority if (i_cfg_wdata == '0) begin
                n_frames = FCNT_W'(1);
            end else if (32'(i_cfg_wdata) > 32'(MAX_FRAMES)) begin
                n_frames = FCNT_W'(MAX_FRAMES);
            end else begin
                n_frames = FCNT_W'(i_cfg_wdata);
            end
        end
    end

    always_comb begin
        n_slot = r_slot;
        if (i_take && !i_freeze && i_frame_end) begin
            n_slot = ((32'(r_slot) + 32'd1) >= 32'(r_frames)) ? '0 : r_slot + FRAME_W'(1);
        end
    end

    assign prod   = PROD_W'(i_random_draw) * PROD_W'(r_frames);
    assign o_pick = prod[sffs_pkg::DRAW_W +: FRAME_W];
    assign o_slot = r_slot;

    always_comb begin
        priority if (i_kind == sffs_pkg::KIND_BIN && 32'(i_bin_index) < 32'(MAX_BINS)) begin
            cls = sffs_pkg::CLS_BIN;
        end else if (i_kind == sffs_pkg::KIND_DC) begin
            cls = sffs_pkg::CLS_DC;
        end else if (i_kind == sffs_pkg::KIND_NYQ) begin
            cls = sffs_pkg::CLS_NYQ;
        end else begin
            cls = sffs_pkg::CLS_ECHO;
        end
    end

    always_comb begin
        o_cmd.cls       = cls;
        o_cmd.freeze    = i_freeze;
        o_cmd.kind      = i_kind;
        o_cmd.bin_index = i_bin_index;
        o_cmd.magnitude = i_magnitude;
        o_cmd.phase     = i_phase;
        o_cmd.frame_end = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FCNT_W'(1);
            r_slot   <= '0;
        end else begin
            r_frames <= n_frames;
            r_slot   <= n_slot;
        end
    end

`ifndef SYNTHESIS
    a_slot_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < 32'(MAX_FRAMES))
        else $error("write slot outside frame store");

    a_frames_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames != '0 && 32'(r_frames) <= 32'(MAX_FRAMES))
        else $error("frame count outside 1..MAX_FRAMES");
`endif

endmodule

`default_nettype wire

// ----- hdl/sffs_back.sv -----
// ----------------------------------------------------------------------------
// sffs_back
// frame stores, running phase, read-modify-write stage with bypass
// ----------------------------------------------------------------------------
`default_nettype none

module sffs_back #(
    parameter int MAX_FRAMES = 64,
    parameter int FRAME_W    = 6,
    parameter int BIN_AW     = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire sffs_pkg::t_cmd      i_cmd,
    input  wire logic [FRAME_W-1:0]  i_pick,
    input  wire logic [FRAME_W-1:0]  i_slot,
    output logic                     o_cmd_pop,
    output logic                     o_busy,
    output logic                     o_res_valid,
    output sffs_pkg::t_res           o_res,
    input  wire logic                i_res_ready
);

    localparam int MAG_W      = sffs_pkg::MAG_W;
    localparam int PH_W       = sffs_pkg::PH_W;
    localparam int MAIN_W     = MAG_W + PH_W;
    localparam int MEM_AW     = FRAME_W + BIN_AW;
    localparam int MEM_DEPTH  = MAX_FRAMES * (2 ** BIN_AW);
    localparam int RP_DEPTH   = 2 ** BIN_AW;
    localparam int EDGE_AW    = FRAME_W + 1;
    localparam int EDGE_DEPTH = 2 * MAX_FRAMES;

    // stores: magnitude and phase step per frame and bin, running phase per bin,
    // dc and nyquist values per frame (select bit in the lsb)
    logic [MAIN_W-1:0] r_main [MEM_DEPTH];
    logic [PH_W-1:0]   r_rp   [RP_DEPTH];
    logic [MAG_W-1:0]  r_edge [EDGE_DEPTH];

    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_cnt;
    logic              clr_edge_ok;

    logic              r_s2_valid;
    sffs_pkg::t_cmd    r_s2_cmd;
    logic [FRAME_W-1:0] r_s2_pick;
    logic [FRAME_W-1:0] r_s2_slot;
    logic [MAIN_W-1:0] r_rd_main;
    logic [PH_W-1:0]   r_rd_rp;
    logic [MAG_W-1:0]  r_rd_edge;

    // bypass of the write that retired on the edge the current item read
    logic              r_fw_main_we;
    logic [MEM_AW-1:0] r_fw_main_addr;
    logic [MAIN_W-1:0] r_fw_main_data;
    logic              r_fw_rp_we;
    logic [BIN_AW-1:0] r_fw_rp_addr;
    logic [PH_W-1:0]   r_fw_rp_data;
    logic              r_fw_edge_we;
    logic [EDGE_AW-1:0] r_fw_edge_addr;
    logic [MAG_W-1:0]  r_fw_edge_data;

    logic              load;
    logic              fire;
    logic [MEM_AW-1:0] rd_main_addr;
    logic [EDGE_AW-1:0] rd_edge_addr;

    logic [BIN_AW-1:0] s2_bin;
    logic [MEM_AW-1:0] s2_main_raddr;
    logic [MEM_AW-1:0] s2_main_waddr;
    logic [EDGE_AW-1:0] s2_edge_raddr;
    logic [EDGE_AW-1:0] s2_edge_waddr;
    logic [MAIN_W-1:0] main_cur;
    logic [PH_W-1:0]   rp_cur;
    logic [MAG_W-1:0]  edge_cur;
    logic [PH_W-1:0]   rp_adv;

    logic              s2_main_we;
    logic [MAIN_W-1:0] s2_main_wdata;
    logic              s2_rp_we;
    logic [PH_W-1:0]   s2_rp_wdata;
    logic              s2_edge_we;
    logic [MAG_W-1:0]  s2_edge_wdata;
    logic              raw_main_we;
    logic              raw_rp_we;
    logic              raw_edge_we;

    logic              main_we;
    logic [MEM_AW-1:0] main_waddr;
    logic [MAIN_W-1:0] main_wdata;
    logic              rp_we;
    logic [BIN_AW-1:0] rp_waddr;
    logic [PH_W-1:0]   rp_wdata;
    logic              edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    logic [MAG_W-1:0]  edge_wdata;

    assign o_busy      = r_clr_busy;
    assign fire        = r_s2_valid && i_res_ready;
    assign load        = i_cmd_valid && !r_clr_busy && (!r_s2_valid || fire);
    assign o_cmd_pop   = load;
    assign o_res_valid = r_s2_valid;

    assign rd_main_addr = {i_pick, i_cmd.bin_index[BIN_AW-1:0]};
    assign rd_edge_addr = {i_pick, (i_cmd.cls == sffs_pkg::CLS_NYQ)};

    assign s2_bin        = r_s2_cmd.bin_index[BIN_AW-1:0];
    assign s2_main_raddr = {r_s2_pick, s2_bin};
    assign s2_main_waddr = {r_s2_slot, s2_bin};
    assign s2_edge_raddr = {r_s2_pick, (r_s2_cmd.cls == sffs_pkg::CLS_NYQ)};
    assign s2_edge_waddr = {r_s2_slot, (r_s2_cmd.cls == sffs_pkg::CLS_NYQ)};

    assign main_cur = (r_fw_main_we && r_fw_main_addr == s2_main_raddr) ? r_fw_main_data
                                                                        : r_rd_main;
    assign rp_cur   = (r_fw_rp_we && r_fw_rp_addr == s2_bin) ? r_fw_rp_data : r_rd_rp;
    assign edge_cur = (r_fw_edge_we && r_fw_edge_addr == s2_edge_raddr) ? r_fw_edge_data
                                                                        : r_rd_edge;
    assign rp_adv   = rp_cur + main_cur[PH_W-1:0];

    always_comb begin
        o_res.kind_out      = r_s2_cmd.kind;
        o_res.bin_out       = r_s2_cmd.bin_index;
        o_res.magnitude_out = r_s2_cmd.magnitude;
        o_res.phase_out     = r_s2_cmd.phase;
        o_res.last          = r_s2_cmd.frame_end;
        raw_main_we   = 1'b0;
        s2_main_wdata = {r_s2_cmd.magnitude, r_s2_cmd.phase - rp_cur};
        raw_rp_we     = 1'b0;
        s2_rp_wdata   = r_s2_cmd.phase;
        raw_edge_we   = 1'b0;
        s2_edge_wdata = r_s2_cmd.magnitude;
        unique case (r_s2_cmd.cls)
            sffs_pkg::CLS_BIN: begin
                raw_rp_we = 1'b1;
                if (r_s2_cmd.freeze) begin
                    o_res.magnitude_out = main_cur[MAIN_W-1:PH_W];
                    o_res.phase_out     = rp_adv;
                    s2_rp_wdata         = rp_adv;
                end else begin
                    raw_main_we = 1'b1;
                end
            end
            sffs_pkg::CLS_DC, sffs_pkg::CLS_NYQ: begin
                o_res.phase_out = '0;
                if (r_s2_cmd.freeze) begin
                    o_res.magnitude_out = edge_cur;
                end else begin
                    raw_edge_we = 1'b1;
                end
            end
            sffs_pkg::CLS_ECHO: begin
            end
            default: begin
            end
        endcase
    end

    assign s2_main_we = raw_main_we && fire;
    assign s2_rp_we   = raw_rp_we && fire;
    assign s2_edge_we = raw_edge_we && fire;

    // clearing pass owns the write ports until it is done
    assign clr_edge_ok = ({1'b0, r_clr_cnt} < (MEM_AW + 1)'(EDGE_DEPTH));
    assign main_we     = r_clr_busy ? 1'b1 : s2_main_we;
    assign main_waddr  = r_clr_busy ? r_clr_cnt : s2_main_waddr;
    assign main_wdata  = r_clr_busy ? '0 : s2_main_wdata;
    assign rp_we       = r_clr_busy ? 1'b1 : s2_rp_we;
    assign rp_waddr    = r_clr_busy ? r_clr_cnt[BIN_AW-1:0] : s2_bin;
    assign rp_wdata    = r_clr_busy ? '0 : s2_rp_wdata;
    assign edge_we     = r_clr_busy ? clr_edge_ok : s2_edge_we;
    assign edge_waddr  = r_clr_busy ? r_clr_cnt[EDGE_AW-1:0] : s2_edge_waddr;
    assign edge_wdata  = r_clr_busy ? '0 : s2_edge_wdata;

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            r_main[main_waddr] <= main_wdata;
        end
        if (load) begin
            r_rd_main <= r_main[rd_main_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rp_we) begin
            r_rp[rp_waddr] <= rp_wdata;
        end
        if (load) begin
            r_rd_rp <= r_rp[i_cmd.bin_index[BIN_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge[edge_waddr] <= edge_wdata;
        end
        if (load) begin
            r_rd_edge <= r_edge[rd_edge_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy   <= 1'b1;
            r_clr_cnt    <= '0;
            r_s2_valid   <= 1'b0;
            r_fw_main_we <= 1'b0;
            r_fw_rp_we   <= 1'b0;
            r_fw_edge_we <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + MEM_AW'(1);
                if (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (load) begin
                r_s2_valid   <= 1'b1;
                r_fw_main_we <= s2_main_we;
                r_fw_rp_we   <= s2_rp_we;
                r_fw_edge_we <= s2_edge_we;
            end else if (fire) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s2_cmd       <= i_cmd;
            r_s2_pick      <= i_pick;
            r_s2_slot      <= i_slot;
            r_fw_main_addr <= s2_main_waddr;
            r_fw_main_data <= s2_main_wdata;
            r_fw_rp_addr   <= s2_bin;
            r_fw_rp_data   <= s2_rp_wdata;
            r_fw_edge_addr <= s2_edge_waddr;
            r_fw_edge_data <= s2_edge_wdata;
        end
    end

`ifndef SYNTHESIS
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |=> !r_clr_busy)
        else $error("clearing pass restarted");

    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s2_valid && !o_cmd_pop)
        else $error("item in flight during clearing pass");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !i_res_ready |=> r_s2_valid && $stable(r_s2_cmd))
        else $error("stalled item lost from execute stage");
`endif

endmodule

`default_nettype wire

// ----- hdl/spectral_freeze_frame_store.sv -----
// ----------------------------------------------------------------------------
// spectral_freeze_frame_store
// records polar spectrum frames and replays randomly picked frames per bin
// ----------------------------------------------------------------------------
// one item per clock cycle, sustained, on both sides, unless full or a
// consumer that stops popping holds the flow; an accepted item is written
// to the front queue on the accepting edge, read from the stores, then
// written to the result queue, where it can be taken. every bin item is
// one read-modify-write of the running phase memory (plus, when recording,
// a frame store write); that single pass through the execute stage sets
// the rate. after reset the block clears its stores, one entry of the frame
// store per cycle, MAX_FRAMES * 2**ceil(log2(min(MAX_BINS, 1024))) entries
// (65536 with the default parameters); full stays high meanwhile, while the
// active_frames register can be written at any time. the register holds the
// number of frames in the circular store and is clamped to 1..MAX_FRAMES.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_freeze_frame_store #(
    parameter int MAX_FRAMES = 64,
    parameter int MAX_BINS   = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration: active_frames
    input  wire logic                               i_cfg_we,
    input  wire logic [sffs_pkg::CFG_W-1:0]         i_cfg_wdata,
    // input queue side
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [sffs_pkg::KIND_W-1:0]        i_kind,
    input  wire logic                               i_freeze,
    input  wire logic [sffs_pkg::BIN_W-1:0]         i_bin_index,
    input  wire logic signed [sffs_pkg::MAG_W-1:0]  i_magnitude,
    input  wire logic [sffs_pkg::PH_W-1:0]          i_phase,
    input  wire logic [sffs_pkg::DRAW_W-1:0]        i_random_draw,
    input  wire logic                               i_frame_end,
    // result queue side
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [sffs_pkg::KIND_W-1:0]             o_kind_out,
    output logic [sffs_pkg::BIN_W-1:0]              o_bin_out,
    output logic signed [sffs_pkg::MAG_W-1:0]       o_magnitude_out,
    output logic [sffs_pkg::PH_W-1:0]               o_phase_out,
    output logic                                    o_last
);

    // frame index width, frame count width
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
    // only bins reachable through the bin field get storage
    localparam int NBINS   = (MAX_BINS < sffs_pkg::BIN_SPAN) ? MAX_BINS : sffs_pkg::BIN_SPAN;
    localparam int BIN_AW  = $clog2(NBINS);
    localparam int CMD_W   = $bits(sffs_pkg::t_cmd) + 2 * FRAME_W;
    localparam int RES_W   = $bits(sffs_pkg::t_res);

    logic               accept;
    logic               busy;

    sffs_pkg::t_cmd     front_cmd;
    logic [FRAME_W-1:0] front_pick;
    logic [FRAME_W-1:0] front_slot;

    logic               midq_full;
    logic               midq_empty;
    logic [CMD_W-1:0]   midq_wdata;
    logic [CMD_W-1:0]   midq_rdata;
    sffs_pkg::t_cmd     back_cmd;
    logic [FRAME_W-1:0] back_pick;
    logic [FRAME_W-1:0] back_slot;
    logic               back_pop;

    logic               res_valid;
    sffs_pkg::t_res     res;
    logic               outq_full;
    logic [RES_W-1:0]   outq_rdata;
    sffs_pkg::t_res     out_res;

    // input side stalls while the stores are cleared or the front queue is full
    assign full   = busy || midq_full;
    assign accept = push && !full;

    // front: frame count, write slot, classification, random frame pick
    sffs_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_BINS   (MAX_BINS),
        .FRAME_W    (FRAME_W),
        .FCNT_W     (FCNT_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_take        (accept),
        .i_kind        (i_kind),
        .i_freeze      (i_freeze),
        .i_bin_index   (i_bin_index),
        .i_magnitude   (i_magnitude),
        .i_phase       (i_phase),
        .i_random_draw (i_random_draw),
        .i_frame_end   (i_frame_end),
        .o_cmd         (front_cmd),
        .o_pick        (front_pick),
        .o_slot        (front_slot)
    );

    // classified items wait here so front and back stall independently
    assign midq_wdata = {front_cmd, front_pick, front_slot};
    assign {back_cmd, back_pick, back_slot} = midq_rdata;

    sffs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (midq_wdata),
        .o_full  (midq_full),
        .i_pop   (back_pop),
        .o_data  (midq_rdata),
        .o_empty (midq_empty)
    );

    // back: store reads, phase update, store writes, clearing pass
    sffs_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .FRAME_W    (FRAME_W),
        .BIN_AW     (BIN_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!midq_empty),
        .i_cmd       (back_cmd),
        .i_pick      (back_pick),
        .i_slot      (back_slot),
        .o_cmd_pop   (back_pop),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (!outq_full)
    );

    // finished items wait here for the consumer
    sffs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (outq_full),
        .i_pop   (pop),
        .o_data  (outq_rdata),
        .o_empty (empty)
    );

    assign out_res         = outq_rdata;
    assign o_kind_out      = out_res.kind_out;
    assign o_bin_out       = out_res.bin_out;
    assign o_magnitude_out = out_res.magnitude_out;
    assign o_phase_out     = out_res.phase_out;
    assign o_last          = out_res.last;

endmodule

`default_nettype wire

// ----- verif/spectral_freeze_frame_store_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_freeze_frame_store_tb
// self-checking bench for the spectral freeze frame store: directed corner
// items, then random record and freeze frames under several frame counts
// ----------------------------------------------------------------------------
// items go in through the push/full queue port and results come back through
// the empty/pop queue port. a scoreboard class keeps its own copy of the
// frame stores, the running phases and the write slot, predicts one result per
// accepted item and checks the results in order. the frame count register is
// only rewritten once every predicted result has come back.
// ----------------------------------------------------------------------------
module spectral_freeze_frame_store_tb;

    localparam int KIND_W   = sffs_pkg::KIND_W;
    localparam int BIN_W    = sffs_pkg::BIN_W;
    localparam int MAG_W    = sffs_pkg::MAG_W;
    localparam int PH_W     = sffs_pkg::PH_W;
    localparam int DRAW_W   = sffs_pkg::DRAW_W;
    localparam int CFG_W    = sffs_pkg::CFG_W;
    localparam int BIN_SPAN = sffs_pkg::BIN_SPAN;

    localparam logic [KIND_W-1:0] KIND_BIN = sffs_pkg::KIND_BIN;
    localparam logic [KIND_W-1:0] KIND_DC  = sffs_pkg::KIND_DC;
    localparam logic [KIND_W-1:0] KIND_NYQ = sffs_pkg::KIND_NYQ;

    localparam int FRAMES_MAX  = 64;       // default MAX_FRAMES of the block
    localparam int WATCH_LIMIT = 200000;   // longer than the clearing pass
    localparam int SETTLE_CYC  = 8;        // pipeline drain plus margin
    localparam int HOLD_CYC    = 300;      // long output stall
    localparam int SHOW_MAX    = 40;       // failing results reported in detail

    // the fourth kind code is not a real item type, the block echoes it
    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;
    localparam logic              MODE_RECORD = 1'b0;
    localparam logic              MODE_FREEZE = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic                    freeze;
        logic [BIN_W-1:0]        bin_index;
        logic signed [MAG_W-1:0] magnitude;
        logic [PH_W-1:0]         phase;
        logic [DRAW_W-1:0]       draw;
        logic                    frame_end;
    } t_item;

    // ------------------------------------------------------------------------
    // scoreboard: frame store predictor plus the queue of results still due
    // ------------------------------------------------------------------------
    class spectral_scoreboard;
        logic [MAG_W-1:0] mag_mem   [FRAMES_MAX*BIN_SPAN];
        logic [PH_W-1:0]  step_mem  [FRAMES_MAX*BIN_SPAN];
        logic [PH_W-1:0]  run_phase [BIN_SPAN];
        logic [MAG_W-1:0] dc_mem    [FRAMES_MAX];
        logic [MAG_W-1:0] nyq_mem   [FRAMES_MAX];
        int unsigned      write_slot;
        int unsigned      active_frames;
        sffs_pkg::t_res   due_results [$];
        int               errors;
        int               checked;
        int               n_record;
        int               n_freeze;
        int               n_echo;

        function new();
            foreach (mag_mem[i]) begin
                mag_mem[i]  = '0;
                step_mem[i] = '0;
            end
            foreach (run_phase[i]) run_phase[i] = '0;
            foreach (dc_mem[i]) begin
                dc_mem[i]  = '0;
                nyq_mem[i] = '0;
            end
            write_slot    = 0;
            active_frames = 1;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            active_frames = 32'(value);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // accepted item: update the stores and queue its result
        function void note_item(t_item it);
            int unsigned    frames;
            int unsigned    draw;
            int unsigned    pick;
            int unsigned    idx;
            sffs_pkg::t_res r;
            frames = active_frames;
            if (frames < 1) frames = 1;
            if (frames > FRAMES_MAX) frames = FRAMES_MAX;
            draw = 32'(it.draw);
            pick = (draw * frames) >> 16;
            r.kind_out      = it.kind;
            r.bin_out       = it.bin_index;
            r.magnitude_out = it.magnitude;
            r.phase_out     = it.phase;
            r.last          = it.frame_end;
            // the bin field cannot exceed the bin count, so no range check here
            if (it.kind == KIND_BIN) begin
                if (it.freeze) begin
                    idx = pick * BIN_SPAN + 32'(it.bin_index);
                    r.magnitude_out = mag_mem[idx];
                    run_phase[it.bin_index] = run_phase[it.bin_index] + step_mem[idx];
                    r.phase_out = run_phase[it.bin_index];
                end else begin
                    idx = write_slot * BIN_SPAN + 32'(it.bin_index);
                    mag_mem[idx]  = it.magnitude;
                    step_mem[idx] = it.phase - run_phase[it.bin_index];
                    run_phase[it.bin_index] = it.phase;
                end
            end else if (it.kind == KIND_DC || it.kind == KIND_NYQ) begin
                if (it.freeze) begin
                    r.magnitude_out = (it.kind == KIND_DC) ? dc_mem[pick] : nyq_mem[pick];
                end else if (it.kind == KIND_DC) begin
                    dc_mem[write_slot] = it.magnitude;
                end else begin
                    nyq_mem[write_slot] = it.magnitude;
                end
                r.phase_out = '0;
            end
            if (it.kind == KIND_OTHER) n_echo++;
            else if (it.freeze) n_freeze++;
            else n_record++;
            // slot moves on any frame end while recording, wraps at the frame count
            if (!it.freeze && it.frame_end) begin
                write_slot = (write_slot + 1 >= frames) ? 0 : write_slot + 1;
            end
            due_results.push_back(r);
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want === got) return 1'b1;
            if (errors < SHOW_MAX) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
            return 1'b0;
        endfunction

        // accepted result: compare with the oldest prediction
        function void check_item(sffs_pkg::t_res got);
            sffs_pkg::t_res want;
            bit             ok;
            checked++;
            if (due_results.size() == 0) begin
                if (errors < SHOW_MAX) begin
                    $display("%0t: result with nothing due: kind %0d bin %0d mag %h",
                             $time, got.kind_out, got.bin_out, got.magnitude_out);
                end
                errors++;
                return;
            end
            want = due_results.pop_front();
            ok = field_ok("kind_out", 32'(want.kind_out), 32'(got.kind_out));
            ok = field_ok("bin_out", 32'(want.bin_out), 32'(got.bin_out)) && ok;
            ok = field_ok("magnitude_out", {8'h00, want.magnitude_out},
                          {8'h00, got.magnitude_out}) && ok;
            ok = field_ok("phase_out", 32'(want.phase_out), 32'(got.phase_out)) && ok;
            ok = field_ok("last", 32'(want.last), 32'(got.last)) && ok;
            if (!ok) errors++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]        i_cfg_wdata   = '0;
    logic                    push          = 1'b0;
    logic                    full;
    logic [KIND_W-1:0]       i_kind        = '0;
    logic                    i_freeze      = 1'b0;
    logic [BIN_W-1:0]        i_bin_index   = '0;
    logic signed [MAG_W-1:0] i_magnitude   = '0;
    logic [PH_W-1:0]         i_phase       = '0;
    logic [DRAW_W-1:0]       i_random_draw = '0;
    logic                    i_frame_end   = 1'b0;
    logic                    empty;
    logic                    pop           = 1'b0;
    logic [KIND_W-1:0]       o_kind_out;
    logic [BIN_W-1:0]        o_bin_out;
    logic signed [MAG_W-1:0] o_magnitude_out;
    logic [PH_W-1:0]         o_phase_out;
    logic                    o_last;

    always #6 i_clk = ~i_clk;

    spectral_freeze_frame_store i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_freeze        (i_freeze),
        .i_bin_index     (i_bin_index),
        .i_magnitude     (i_magnitude),
        .i_phase         (i_phase),
        .i_random_draw   (i_random_draw),
        .i_frame_end     (i_frame_end),
        .empty           (empty),
        .pop             (pop),
        .o_kind_out      (o_kind_out),
        .o_bin_out       (o_bin_out),
        .o_magnitude_out (o_magnitude_out),
        .o_phase_out     (o_phase_out),
        .o_last          (o_last)
    );

    spectral_scoreboard sb = new();

    t_item stim_q [$];       // items waiting to be offered
    t_item offered;          // item currently on the input ports
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    stall_req     = 1'b0;
    int    stall_left    = 0;
    int    quiet_cycles  = 0;
    int    cfg_random    = 0;

    // ------------------------------------------------------------------------
    // input side: offer queued items, idle at random between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) sb.note_item(offered);
            // a new item may go out once the current one is taken or none is up
            if (!push || !full) begin
                if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = stim_q.pop_front();
                    push          <= 1'b1;
                    i_kind        <= offered.kind;
                    i_freeze      <= offered.freeze;
                    i_bin_index   <= offered.bin_index;
                    i_magnitude   <= offered.magnitude;
                    i_phase       <= offered.phase;
                    i_random_draw <= offered.draw;
                    i_frame_end   <= offered.frame_end;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: take results, stall at random or for a long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        sffs_pkg::t_res got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.kind_out      = o_kind_out;
                got.bin_out       = o_bin_out;
                got.magnitude_out = o_magnitude_out;
                got.phase_out     = o_phase_out;
                got.last          = o_last;
                sb.check_item(got);
            end
            if (stall_req) begin
                stall_left = HOLD_CYC;
                stall_req  = 1'b0;
            end
            if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any item moving on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [KIND_W-1:0] kind, logic frz,
                                       logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag,
                                       logic [PH_W-1:0] ph, logic [DRAW_W-1:0] draw,
                                       logic fend);
        t_item it;
        it.kind      = kind;
        it.freeze    = frz;
        it.bin_index = bin;
        it.magnitude = mag;
        it.phase     = ph;
        it.draw      = draw;
        it.frame_end = fend;
        stim_q.push_back(it);
    endfunction

    // mostly well formed frames (dc, a few bins, nyquist with frame end),
    // some with the frame end missing or an echo item inside, plus noise
    function automatic void queue_frames(int n);
        int   made;
        int   roll;
        int   nb;
        int   base;
        logic frz;
        made = 0;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                queue_item(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           BIN_W'($urandom_range(0, BIN_SPAN - 1)), MAG_W'($urandom),
                           PH_W'($urandom_range(0, 65535)),
                           DRAW_W'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
                made++;
            end else begin
                frz = (roll < 40) ? MODE_FREEZE : MODE_RECORD;
                nb  = $urandom_range(1, 6);
                // bin groups at the bottom, at the top, at bin 16 or at a random base, so replays land on recorded bins
                case ($urandom_range(0, 3))
                    0: begin
                        base = 0;
                    end
                    1: begin
                        base = BIN_SPAN - nb;
                    end
                    2: begin
                        base = int'($urandom_range(0, BIN_SPAN - nb));
                    end
                    default: begin
                        base = 16;
                    end
                endcase
                queue_item(KIND_DC, frz, BIN_W'($urandom_range(0, BIN_SPAN - 1)),
                           MAG_W'($urandom), PH_W'($urandom_range(0, 65535)),
                           DRAW_W'($urandom_range(0, 65535)), 1'b0);
                for (int b = 0; b < nb; b++) begin
                    queue_item(KIND_BIN, frz, BIN_W'(base + b), MAG_W'($urandom),
                               PH_W'($urandom_range(0, 65535)),
                               DRAW_W'($urandom_range(0, 65535)), 1'b0);
                    if ($urandom_range(0, 19) == 0) begin
                        queue_item(KIND_OTHER, frz, BIN_W'($urandom_range(0, BIN_SPAN - 1)),
                                   MAG_W'($urandom), PH_W'($urandom_range(0, 65535)),
                                   DRAW_W'($urandom_range(0, 65535)), 1'b0);
                        made++;
                    end
                end
                queue_item(KIND_NYQ, frz, BIN_W'($urandom_range(0, BIN_SPAN - 1)),
                           MAG_W'($urandom), PH_W'($urandom_range(0, 65535)),
                           DRAW_W'($urandom_range(0, 65535)),
                           $urandom_range(0, 9) != 0);
                made += nb + 2;
            end
        end
    endfunction

    // everything offered, taken and checked, then let the pipeline settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (stim_q.size() != 0 || push || sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // new phase: drain, set idling, write the frame count while idle
    task automatic start_phase(logic [CFG_W-1:0] frames, int send_pct, int recv_pct);
        wait_drained();
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= frames;
        sb.set_frames(frames);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, frame count zero (acts as one)
        start_phase(7'd0, 13, 51);
        // freeze before anything was recorded replays cleared stores
        queue_item(KIND_BIN, MODE_FREEZE, 10'd0, 24'h000000, 16'h1234, 16'hFFFF, 1'b0);
        queue_item(KIND_DC, MODE_FREEZE, 10'd0, 24'h7FFFFF, 16'hFFFF, 16'h0000, 1'b0);
        // frame end in freeze mode leaves the slot alone
        queue_item(KIND_NYQ, MODE_FREEZE, 10'd1023, 24'h800000, 16'h0000, 16'hFFFF, 1'b1);
        // record extremes of magnitude, phase and bin
        queue_item(KIND_DC, MODE_RECORD, 10'd0, 24'h800000, 16'hFFFF, 16'h0000, 1'b0);
        queue_item(KIND_BIN, MODE_RECORD, 10'd0, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(KIND_BIN, MODE_RECORD, 10'd1023, 24'h800000, 16'h0000, 16'h8000, 1'b0);
        queue_item(KIND_BIN, MODE_RECORD, 10'd1023, 24'h000001, 16'h8000, 16'h0001, 1'b0);
        // echo item with frame end still moves the slot while recording
        queue_item(KIND_OTHER, MODE_RECORD, 10'h2AA, 24'h123456, 16'hABCD, 16'h5555, 1'b1);
        queue_item(KIND_NYQ, MODE_RECORD, 10'h155, 24'h7FFFFF, 16'h5555, 16'hAAAA, 1'b1);
        // replay what was just recorded, phases accumulate
        queue_item(KIND_BIN, MODE_FREEZE, 10'd0, 24'h000000, 16'h0000, 16'h0000, 1'b0);
        queue_item(KIND_BIN, MODE_FREEZE, 10'd0, 24'h000000, 16'h0000, 16'hFFFF, 1'b0);
        queue_item(KIND_BIN, MODE_FREEZE, 10'd1023, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(KIND_DC, MODE_FREEZE, 10'd5, 24'h000000, 16'h0000, 16'h8000, 1'b0);
        queue_item(KIND_NYQ, MODE_FREEZE, 10'd6, 24'h000000, 16'h0000, 16'hFFFF, 1'b0);
        queue_item(KIND_OTHER, MODE_FREEZE, 10'd1023, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        // random frames under a handful of frame counts
        start_phase(7'd5, 13, 51);
        queue_frames(300);

        start_phase(7'd64, 51, 13);
        queue_frames(400);

        // count lowered below the current slot; long output stall fills the block
        start_phase(7'd3, 0, 0);
        queue_frames(250);
        stall_req = 1'b1;

        // above the store size, clamps to the largest count
        start_phase(7'd127, 0, 0);
        queue_frames(250);

        cfg_random = $urandom_range(2, 126);
        start_phase(CFG_W'(cfg_random), 0, 0);
        queue_frames(100);

        wait_drained();

        $display("covered %0d recorded, %0d replayed and %0d echoed items, %0d results",
                 sb.n_record, sb.n_freeze, sb.n_echo, sb.checked);
        $display("frame counts 0, 3, 5, 64, 127 and %0d, three idling mixes, one long stall",
                 cfg_random);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
